// ----- rtl/led_indicator_sequencer_assert.svh -----
// ----------------------------------------------------------------------------
// led_indicator_sequencer_assert.svh
// assertion macros shared by the indicator sequencer rtl
// ----------------------------------------------------------------------------
`ifndef LED_INDICATOR_SEQUENCER_ASSERT_SVH
`define LED_INDICATOR_SEQUENCER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define LIS_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition that must hold on every clock edge outside reset
`define LIS_ASSERT_ALWAYS(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("assertion failed");

`endif

// ----- rtl/lis_pkg.sv -----
// ----------------------------------------------------------------------------
// lis_pkg
// types and constants of the indicator sequencer
// ----------------------------------------------------------------------------
package lis_pkg;

  localparam int unsigned LineW = 7;

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_ON    = 3'd1,
    REQ_FLASH = 3'd2,
    REQ_OFF   = 3'd3,
    REQ_QUERY = 3'd4,
    REQ_CLEAR = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_PERM  = 2'd2,
    MODE_FLASH = 2'd3
  } mode_e;

  localparam logic [1:0] ColNone  = 2'd0;
  localparam logic [1:0] ColBlue  = 2'd1;
  localparam logic [1:0] ColGreen = 2'd2;
  localparam logic [1:0] ColRed   = 2'd3;

  // per-led task entry, one memory word
  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  colour;
    logic [7:0]  level;
    logic [15:0] timeout;
    logic [12:0] interval;
    logic [12:0] tick_cnt;
    logic [7:0]  toggles;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // fixed colour to line wiring
  function automatic logic [LineW-1:0] line_of(input logic [1:0] led, input logic [1:0] col);
    logic [LineW-1:0] m;
    m = '0;
    case (col)
      ColBlue:  m[led] = 1'b1;
      ColGreen: begin
        if (led == 2'd1) m[4] = 1'b1;
        if (led == 2'd3) m[5] = 1'b1;
      end
      ColRed:   if (led != 2'd3) m[6] = 1'b1;
      default:  m = '0;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/lis_ram.sv -----
// ----------------------------------------------------------------------------
// lis_ram
// simple dual port synchronous ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module lis_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- rtl/led_indicator_sequencer.sv -----
// ----------------------------------------------------------------------------
// led_indicator_sequencer
// four led indicator sequencer with timed, permanent and flashing tasks
// ----------------------------------------------------------------------------
// Usage: requests arrive on the s_axis channel, one result per request leaves
// on the m_axis channel. Per-led task entries live in a small ram that is read,
// updated and written back one entry at a time.
// A tick request visits all four entries: a read state, then one update per
// led in the work state, then the result is formed in the output state.
// Set, off and query requests touch one entry: read, then update.
// Clear all sweeps the four entries, one per cycle.
// The next request is taken the cycle after a result loads, so the block does
// not take a new request while one is still in progress.
// The registered ram read and the one-entry-per-cycle update loop set the pace.
// After reset the ram is swept once, writing empty entries before the first
// request is taken. Lamp lines start all off.
// The result register holds one result; while the receiver stalls, the
// block finishes the next request's work but waits to load the result
// until the register frees up.
// ----------------------------------------------------------------------------
module led_indicator_sequencer
  import lis_pkg::*;
#(
  parameter int unsigned TICKS_PER_SLOW = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // req_type[2:0], led_index[4:3], colour[6:5], timeout_seconds[19:7],
  // task_priority[27:20], flash_period_ms[43:28], flash_pulses[50:44]
  input  logic [55:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // accepted[0], led_active[1], lamp_lines[8:2], finished_mask[12:9]
  output logic [15:0] m_axis_tdata_o
);

  typedef enum logic [4:0] {
    ST_INIT  = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_WORK  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic [3:0] pre_q, pre_d;
  logic       slow_q, slow_d;
  logic [LineW-1:0] lamp_q, lamp_d;
  logic [3:0] done_q, done_d;
  logic       acc_q, acc_d, act_q, act_d;

  // request fields captured on a transfer
  logic [2:0]  req_q;
  logic [1:0]  led_q, col_q;
  logic [12:0] secs_q;
  logic [7:0]  prio_q;
  logic [15:0] per_q;
  logic [6:0]  pul_q;

  logic        ovalid_q;
  logic [15:0] odata_q;

  logic        we;
  logic [1:0]  raddr;
  entry_t      wdata, rd;

  lis_ram #(.Width(EntryW), .Depth(4)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  wire in_xfer = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  // capture request
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q  <= s_axis_tdata_i[2:0];
      led_q  <= s_axis_tdata_i[4:3];
      col_q  <= s_axis_tdata_i[6:5];
      secs_q <= s_axis_tdata_i[19:7];
      prio_q <= s_axis_tdata_i[27:20];
      per_q  <= s_axis_tdata_i[43:28];
      pul_q  <= s_axis_tdata_i[50:44];
    end
  end

  // per-entry datapath
  entry_t   e;
  logic [LineW-1:0] lamp_w;
  logic [3:0] done_w;
  logic       acc_w, act_w;
  logic [LineW-1:0] nl;
  logic [16:0] t10;
  logic [15:0] tsat;
  logic [12:0] tc;
  logic [31:0] per_mul;
  logic        fin, skip;

  always_comb begin
    e = rd;
    lamp_w = lamp_q;
    done_w = done_q;
    acc_w = acc_q;
    act_w = act_q;
    we = 1'b0;
    wdata = rd;
    fin = 1'b0;
    skip = 1'b0;
    tc = '0;
    nl = line_of(led_q, col_q);
    t10 = {1'b0, secs_q, 3'b000} + {3'b000, secs_q, 1'b0};
    tsat = t10[16] ? 16'hFFFF : t10[15:0];
    // period divided by ten through a reciprocal multiply, exact for 16 bits
    per_mul = 32'(per_q) * 32'd52429;
    case (req_q)
      REQ_TICK: begin
        we = 1'b1;
        if (rd.mode != MODE_OFF) begin
          if (rd.mode == MODE_FLASH) begin
            tc = rd.tick_cnt + 13'd1;
            e.tick_cnt = tc;
            if (tc >= rd.interval) begin
              e.tick_cnt = '0;
              lamp_w = lamp_w ^ line_of(idx_q, rd.colour);
              if (rd.toggles != 8'd0) begin
                e.toggles = rd.toggles - 8'd1;
                if (e.toggles == 8'd0) begin
                  fin = 1'b1;
                  skip = 1'b1;
                end
              end
            end
          end
          if (!skip && slow_q && rd.timeout != 16'd0) begin
            e.timeout = rd.timeout - 16'd1;
            if (e.timeout == 16'd0) fin = 1'b1;
          end
          if (fin) begin
            lamp_w = lamp_w & ~line_of(idx_q, rd.colour);
            e.mode = MODE_OFF;
            e.colour = ColNone;
            e.timeout = '0;
            e.level = '0;
            done_w[idx_q] = 1'b1;
          end
        end
        wdata = e;
      end
      REQ_ON, REQ_FLASH: begin
        acc_w = 1'b0;
        if (col_q != ColNone && nl != '0 &&
            !(rd.mode != MODE_OFF && rd.level > prio_q)) begin
          if (rd.colour != ColNone && rd.colour != col_q)
            lamp_w = lamp_w & ~line_of(led_q, rd.colour);
          e.colour = col_q;
          e.timeout = tsat;
          e.level = prio_q;
          if (req_q == REQ_ON) begin
            e.mode = (secs_q == '0) ? MODE_PERM : MODE_ON;
            lamp_w = lamp_w | nl;
          end else begin
            e.mode = MODE_FLASH;
            e.interval = per_mul[31:19];
            e.tick_cnt = '0;
            e.toggles = {pul_q, 1'b0};
            lamp_w = lamp_w & ~nl;
          end
          acc_w = 1'b1;
          we = 1'b1;
        end
        wdata = e;
      end
      REQ_OFF: begin
        lamp_w = lamp_w & ~line_of(led_q, rd.colour);
        e.mode = MODE_OFF;
        e.colour = ColNone;
        e.timeout = '0;
        e.level = '0;
        we = 1'b1;
        wdata = e;
      end
      REQ_QUERY: act_w = (rd.mode != MODE_OFF);
      REQ_CLEAR: begin
        e.mode = MODE_OFF;
        e.colour = ColNone;
        e.timeout = '0;
        e.level = '0;
        lamp_w = '0;
        we = 1'b1;
        wdata = e;
      end
      default: acc_w = 1'b0;
    endcase
    if (state_q == ST_INIT) begin
      we = 1'b1;
      wdata = '0;
    end else if (state_q != ST_WORK) begin
      we = 1'b0;
    end
  end

  // tick and clear visit every entry, others only led_index
  wire multi = (req_q == REQ_TICK) || (req_q == REQ_CLEAR);
  always_comb begin
    raddr = multi ? idx_q : led_q;
    if (state_q == ST_WORK && multi) raddr = idx_q + 2'd1;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    pre_d = pre_q;
    slow_d = slow_q;
    lamp_d = lamp_q;
    done_d = done_q;
    acc_d = acc_q;
    act_d = act_q;
    case (state_q)
      ST_INIT: begin
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) state_d = ST_IDLE;
      end
      ST_IDLE: if (in_xfer) begin
        state_d = ST_READ;
        idx_d = '0;
      end
      ST_READ: begin
        state_d = ST_WORK;
        done_d = '0;
        act_d = 1'b0;
        acc_d = (req_q <= REQ_CLEAR);
        if (req_q == REQ_TICK) begin
          if (pre_q + 4'd1 >= 4'(TICKS_PER_SLOW)) begin
            pre_d = '0;
            slow_d = 1'b1;
          end else begin
            pre_d = pre_q + 4'd1;
            slow_d = 1'b0;
          end
        end
        if (!multi) idx_d = led_q;
      end
      ST_WORK: begin
        lamp_d = lamp_w;
        done_d = done_w;
        acc_d = acc_w;
        act_d = act_w;
        idx_d = idx_q + 2'd1;
        if (!multi || idx_q == 2'd3) state_d = ST_OUT;
      end
      ST_OUT: if (!ovalid_q || m_axis_tready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      idx_q <= '0;
      pre_q <= '0;
      slow_q <= 1'b0;
      lamp_q <= '0;
      done_q <= '0;
      acc_q <= 1'b0;
      act_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      pre_q <= pre_d;
      slow_q <= slow_d;
      lamp_q <= lamp_d;
      done_q <= done_d;
      acc_q <= acc_d;
      act_q <= act_d;
      if (state_q == ST_OUT && (!ovalid_q || m_axis_tready_i)) ovalid_q <= 1'b1;
      else if (m_axis_tready_i) ovalid_q <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && (!ovalid_q || m_axis_tready_i))
      odata_q <= {3'b000, done_q, lamp_q, act_q, acc_q};
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o = odata_q;

`include "led_indicator_sequencer_assert.svh"

  `LIS_ASSERT_ALWAYS(a_onehot, clk_i, rst_ni, $onehot(state_q))
  `LIS_ASSERT_IMP(a_done_tick, clk_i, rst_ni, state_q == ST_OUT && req_q != REQ_TICK, done_q == 4'd0)
  `LIS_ASSERT_IMP(a_act_query, clk_i, rst_ni, state_q == ST_OUT && req_q != REQ_QUERY, act_q == 1'b0)
  `LIS_ASSERT_IMP(a_pre_range, clk_i, rst_ni, 1'b1, pre_q < 4'(TICKS_PER_SLOW))

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the four led indicator sequencer: requests are sent
// with random gaps, a behavioral predictor computes each result and a monitor
// compares every returned transfer field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import lis_pkg::*;

  localparam int unsigned SlowTicks = 10;

  typedef struct packed {
    logic [3:0] finished;
    logic [6:0] lamps;
    logic       active;
    logic       accepted;
  } result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;

  led_indicator_sequencer #(.TICKS_PER_SLOW(SlowTicks)) dut (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  // predictor state
  mode_e       p_mode [4];
  logic [1:0]  p_col [4];
  logic [7:0]  p_lvl [4];
  logic [15:0] p_tmo [4];
  logic [12:0] p_ivl [4];
  logic [12:0] p_cnt [4];
  logic [7:0]  p_tog [4];
  logic [6:0]  p_lamps;
  logic [3:0]  p_pre;

  result_t expected_results[$];
  int      n_errors;
  int      n_checked;
  int      n_sent;
  bit      stall_hard;

  initial begin
    clk_i = 1'b0;
    forever begin
      #5 clk_i = 1'b1;
      #5 clk_i = 1'b0;
    end
  end

  initial begin
    #200ms;
    $display("timeout at %0t", $time);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [6:0] wire_of(input logic [1:0] led, input logic [1:0] col);
    logic [6:0] m;
    m = '0;
    if (col == ColBlue) m[led] = 1'b1;
    else if (col == ColGreen) begin
      if (led == 2'd1) m[4] = 1'b1;
      if (led == 2'd3) m[5] = 1'b1;
    end else if (col == ColRed && led != 2'd3) m[6] = 1'b1;
    return m;
  endfunction

  function automatic void lamp_clear(input logic [1:0] led, input logic [1:0] col);
    p_lamps = p_lamps & ~wire_of(led, col);
  endfunction

  function automatic void drop_led(input int i);
    p_mode[i] = MODE_OFF;
    p_col[i]  = ColNone;
    p_tmo[i]  = '0;
    p_lvl[i]  = '0;
  endfunction

  function automatic void predictor_reset();
    for (int i = 0; i < 4; i++) begin
      drop_led(i);
      p_ivl[i] = '0;
      p_cnt[i] = '0;
      p_tog[i] = '0;
    end
    p_lamps = '0;
    p_pre   = '0;
  endfunction

  // common acceptance and setup of set on and set flash
  function automatic bit claim_led(input logic [1:0] led, input logic [1:0] col,
                                   input logic [7:0] prio, input logic [12:0] secs);
    int unsigned t;
    if (col == ColNone || wire_of(led, col) == '0) return 1'b0;
    if (p_mode[led] != MODE_OFF && p_lvl[led] > prio) return 1'b0;
    if (p_col[led] != ColNone && p_col[led] != col) lamp_clear(led, p_col[led]);
    t = secs * 10;
    if (t > 16'hFFFF) t = 16'hFFFF;
    p_col[led] = col;
    p_tmo[led] = t[15:0];
    p_lvl[led] = prio;
    return 1'b1;
  endfunction

  function automatic logic [3:0] advance_tick();
    logic [3:0] done;
    bit slow;
    int unsigned c;
    done = '0;
    c = p_pre + 1;
    slow = 1'b0;
    if (c >= SlowTicks) begin
      c = 0;
      slow = 1'b1;
    end
    p_pre = c[3:0];
    for (int i = 0; i < 4; i++) begin
      if (p_mode[i] == MODE_OFF) continue;
      if (p_mode[i] == MODE_FLASH) begin
        p_cnt[i] = p_cnt[i] + 13'd1;
        if (p_cnt[i] >= p_ivl[i]) begin
          p_cnt[i] = '0;
          p_lamps = p_lamps ^ wire_of(i[1:0], p_col[i]);
          if (p_tog[i] > 0) begin
            p_tog[i]--;
            if (p_tog[i] == 0) begin
              lamp_clear(i[1:0], p_col[i]);
              drop_led(i);
              done[i] = 1'b1;
              continue;
            end
          end
        end
      end
      if (slow && p_tmo[i] > 0) begin
        p_tmo[i]--;
        if (p_tmo[i] == 0) begin
          lamp_clear(i[1:0], p_col[i]);
          drop_led(i);
          done[i] = 1'b1;
        end
      end
    end
    return done;
  endfunction

  function automatic result_t predict_request(input logic [55:0] d);
    result_t r;
    logic [2:0]  req;
    logic [1:0]  led, col;
    logic [12:0] secs;
    logic [7:0]  prio;
    logic [15:0] period;
    logic [6:0]  pulses;
    req = d[2:0]; led = d[4:3]; col = d[6:5]; secs = d[19:7];
    prio = d[27:20]; period = d[43:28]; pulses = d[50:44];
    r = '0;
    case (req)
      REQ_TICK: begin
        r.finished = advance_tick();
        r.accepted = 1'b1;
      end
      REQ_ON: if (claim_led(led, col, prio, secs)) begin
        p_mode[led] = (secs == 0) ? MODE_PERM : MODE_ON;
        p_lamps = p_lamps | wire_of(led, col);
        r.accepted = 1'b1;
      end
      REQ_FLASH: if (claim_led(led, col, prio, secs)) begin
        p_mode[led] = MODE_FLASH;
        p_ivl[led] = 13'(period / 10);
        p_cnt[led] = '0;
        p_tog[led] = {pulses, 1'b0};
        lamp_clear(led, col);
        r.accepted = 1'b1;
      end
      REQ_OFF: begin
        if (p_col[led] != ColNone) lamp_clear(led, p_col[led]);
        drop_led(led);
        r.accepted = 1'b1;
      end
      REQ_QUERY: begin
        r.active = (p_mode[led] != MODE_OFF);
        r.accepted = 1'b1;
      end
      REQ_CLEAR: begin
        for (int i = 0; i < 4; i++) drop_led(i);
        p_lamps = '0;
        r.accepted = 1'b1;
      end
      default: ;
    endcase
    r.lamps = p_lamps;
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 30);
    return $urandom_range(0, 2);
  endfunction

  // send one request and record its expected result
  task automatic send_request(input logic [2:0] req, input logic [1:0] led,
                              input logic [1:0] col, input logic [12:0] secs,
                              input logic [7:0] prio, input logic [15:0] period,
                              input logic [6:0] pulses);
    logic [55:0] d;
    int g;
    d = {5'd0, pulses, period, prio, secs, col, led, req};
    g = gap_len();
    // valid drops only when a gap follows, so back to back sends keep it high
    if (g != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= d;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_results.push_back(predict_request(d));
    n_sent++;
  endtask

  task automatic send_tick();
    send_request(REQ_TICK, 2'($urandom), 2'($urandom), 13'($urandom), 8'($urandom),
                 16'($urandom), 7'($urandom));
  endtask

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        result_t got, exp_r;
        got = result_t'(m_axis_tdata_o[12:0]);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          n_errors++;
        end else begin
          exp_r = expected_results.pop_front();
          n_checked++;
          if (got.accepted !== exp_r.accepted) begin
            $display("%0t: accepted exp %b got %b", $time, exp_r.accepted, got.accepted);
            n_errors++;
          end
          if (got.active !== exp_r.active) begin
            $display("%0t: led_active exp %b got %b", $time, exp_r.active, got.active);
            n_errors++;
          end
          if (got.lamps !== exp_r.lamps) begin
            $display("%0t: lamp_lines exp %h got %h", $time, exp_r.lamps, got.lamps);
            n_errors++;
          end
          if (got.finished !== exp_r.finished) begin
            $display("%0t: finished_mask exp %h got %h", $time, exp_r.finished,
                     got.finished);
            n_errors++;
          end
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_hard <= ~stall_hard;
    if (stall_hard) m_axis_tready_i <= ($urandom_range(0, 9) == 0);
    else m_axis_tready_i <= ($urandom_range(0, 4) != 0);
  end

  task automatic test_directed();
    logic [1:0] i;
    // every colour on every led, including those without a line
    for (int k = 0; k < 4; k++)
      for (int c = 0; c < 4; c++)
        send_request(REQ_ON, k[1:0], c[1:0], 13'd0, 8'd5, 16'd0, 7'd0);
    // lower priority rejected, equal replaces
    send_request(REQ_ON, 2'd0, ColBlue, 13'd1, 8'd4, 16'd0, 7'd0);
    send_request(REQ_FLASH, 2'd0, ColRed, 13'd0, 8'd5, 16'd5, 7'd2);
    send_request(REQ_QUERY, 2'd0, ColNone, 13'd0, 8'd0, 16'd0, 7'd0);
    send_request(REQ_ON, 2'd1, ColRed, 13'd8191, 8'd255, 16'hFFFF, 7'd127);
    repeat (5) send_tick();
    send_request(REQ_OFF, 2'd1, ColNone, 13'd0, 8'd0, 16'd0, 7'd0);
    send_request(3'd6, 2'd2, ColBlue, 13'd0, 8'd0, 16'd0, 7'd0);
    send_request(3'd7, 2'd3, ColRed, 13'h1FFF, 8'hFF, 16'hFFFF, 7'h7F);
    send_request(REQ_CLEAR, 2'd0, ColNone, 13'd0, 8'd0, 16'd0, 7'd0);
    i = 2'd3;
    send_request(REQ_QUERY, i, ColNone, 13'd0, 8'd0, 16'd0, 7'd0);
  endtask

  // mostly plausible tasks with runs of ticks so timeouts and flashes finish
  task automatic test_random(input int count);
    int n;
    logic [2:0] req;
    logic [12:0] secs;
    logic [15:0] period;
    n = 0;
    while (n < count) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        repeat ($urandom_range(1, 12)) begin
          send_tick();
          n++;
        end
        continue;
      end
      if (r < 70) req = REQ_ON;
      else if (r < 85) req = REQ_FLASH;
      else if (r < 90) req = REQ_OFF;
      else if (r < 95) req = REQ_QUERY;
      else if (r < 97) req = REQ_CLEAR;
      else req = 3'($urandom_range(6, 7));
      secs = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 3));
      period = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
      send_request(req, 2'($urandom), 2'($urandom), secs, 8'($urandom), period,
                   ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 3)));
      n++;
    end
  endtask

  initial begin
    int w;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    n_errors = 0;
    n_checked = 0;
    n_sent = 0;
    predictor_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(1600);
    s_axis_tvalid_i <= 1'b0;
    w = 0;
    while (expected_results.size() != 0 && w < 100000) begin
      @(posedge clk_i);
      w++;
    end
    repeat (20) @(posedge clk_i);
    $display("sent %0d requests, checked %0d results", n_sent, n_checked);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
